>>> design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the structured Hadamard apply core.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned MaxLog2    = 10;
  localparam int unsigned IdxW       = MaxLog2;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned SingW      = 16;
  localparam int unsigned SingFrac   = 12;
  localparam int unsigned WorkW      = 52;
  localparam int unsigned StageW     = 4;
  localparam int unsigned PaddrW     = 3;

  typedef enum logic [1:0] {
    OP_LOAD_TABLE  = 2'd0,
    OP_LOAD_SAMPLE = 2'd1,
    OP_READ        = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_LOG2_SIZE = 1'b0,
    REG_TRANSPOSE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G_PERM,
    ST_G_SAMP,
    ST_G_WR,
    ST_B_RD,
    ST_B_WA,
    ST_B_WB,
    ST_S_RD,
    ST_S_MUL,
    ST_S_WR,
    ST_F_RD,
    ST_F_ADD,
    ST_F_WR
  } state_e;

endpackage

>>> design/sha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  element_index;
  logic signed [15:0] sample_value;
  logic        last_sample;
  logic [9:0]  right_perm_entry;
  logic [9:0]  left_perm_entry;
  logic        right_sign_bit;
  logic        left_sign_bit;
  logic [15:0] singular_entry;

  modport source (output valid, operation, element_index, sample_value, last_sample,
                  right_perm_entry, left_perm_entry, right_sign_bit, left_sign_bit,
                  singular_entry, input ready);
  modport sink (input valid, operation, element_index, sample_value, last_sample,
                right_perm_entry, left_perm_entry, right_sign_bit, left_sign_bit,
                singular_entry, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] result_value;
  logic [9:0]  result_index;
  logic        saturated;

  modport source (output valid, result_value, result_index, saturated, input ready);
  modport sink (input valid, result_value, result_index, saturated, output ready);
endinterface

>>> design/structured_hadamard_apply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// structured_hadamard_apply_core
// Computes y = P_u H D S D H P_v x for one column held in on-chip memories.
// ----------------------------------------------------------------------------
// Load and read items are accepted while the core is idle and the result
// side is not stalled; a read returns its result through the out_mem read
// register and then the output register. The last sample starts the
// transform, during which no item is accepted: gather (permute, read, write
// per element), two butterfly passes (read, write sum, write difference per
// pair), scaling and the final round/scatter (read, compute, write per element).
// ----------------------------------------------------------------------------
module structured_hadamard_apply_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  sha_in_if.sink                  item_in_i,
  sha_out_if.source               result_out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [sha_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import sha_pkg::*;

  logic [3:0]         log2_size_q;
  logic               transpose_q;
  state_e             state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-2:0]    pair_q, pair_d;
  logic [StageW-1:0]  stage_q, stage_d;
  logic               second_q, second_d;

  logic [StageW-1:0]  lg;
  logic [IdxW-1:0]    msk;
  logic [4:0]         shamt;

  logic [SampleW-1:0] samp_mem [2**IdxW];
  logic [WorkW-1:0]   work_mem [2**IdxW];
  logic [SampleW:0]   out_mem  [2**IdxW];
  logic [IdxW-1:0]    rperm_mem [2**IdxW];
  logic [IdxW-1:0]    lperm_mem [2**IdxW];
  logic [1:0]         sign_mem [2**IdxW];
  logic [SingW-1:0]   sing_mem [2**IdxW];

  logic [SampleW-1:0] samp_rd;
  logic [WorkW-1:0]   work_rd_a, work_rd_b;
  logic [SampleW:0]   out_rd;
  logic [IdxW-1:0]    rperm_rd, lperm_rd;
  logic [1:0]         sign_rd;
  logic [SingW-1:0]   sing_rd;

  logic               in_acc, tab_we, samp_we, out_re, start;
  logic               tab_re, samp_re, work_re, work_we, out_we;
  logic [IdxW-1:0]    samp_ra, work_ra_a, work_ra_b, work_wa, out_wa;
  logic [WorkW-1:0]   work_wd;
  logic [SampleW:0]   out_wd;
  logic [IdxW-1:0]    addr_a, addr_b, gperm, sperm;

  logic signed [43:0]     prod_q;
  logic                   neg_q;
  logic signed [WorkW-1:0] sum_q, shifted;
  logic                   sat;
  logic [SampleW-1:0]     res16;

  logic               rd_pend_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic               ovalid_q;
  logic               move;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_size_q <= 4'd10;
      transpose_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_LOG2_SIZE: log2_size_q <= pwdata[3:0];
        REG_TRANSPOSE: transpose_q <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_e'(paddr[2]))
      REG_LOG2_SIZE: prdata = {28'd0, log2_size_q};
      REG_TRANSPOSE: prdata = {31'd0, transpose_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign lg    = (log2_size_q > StageW'(MaxLog2)) ? StageW'(MaxLog2) : log2_size_q;
  assign msk   = IdxW'((11'd1 << lg) - 11'd1);
  assign shamt = 5'(lg) + 5'(SingFrac);

  // input side
  assign item_in_i.ready = (state_q == ST_IDLE) &&
                           !(rd_pend_q && ovalid_q && !result_out_o.ready);
  assign in_acc  = item_in_i.valid && item_in_i.ready;
  assign tab_we  = in_acc && (op_e'(item_in_i.operation) == OP_LOAD_TABLE);
  assign samp_we = in_acc && (op_e'(item_in_i.operation) == OP_LOAD_SAMPLE);
  assign out_re  = in_acc && (op_e'(item_in_i.operation) == OP_READ);
  assign start   = samp_we && item_in_i.last_sample;

  assign gperm = (transpose_q ? lperm_rd : rperm_rd) & msk;
  assign sperm = (transpose_q ? rperm_rd : lperm_rd) & msk;
  assign addr_a = IdxW'(((11'(pair_q)) >> stage_q) << (stage_q + 4'd1)) |
                  (IdxW'(pair_q) & IdxW'((11'd1 << stage_q) - 11'd1));
  assign addr_b = addr_a | IdxW'(11'd1 << stage_q);

  assign shifted = sum_q >>> shamt;
  assign sat     = (shifted > 52'sd32767) || (shifted < -52'sd32768);
  assign res16   = shifted[WorkW-1] ? 16'h8000 : 16'h7fff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      pair_q   <= '0;
      stage_q  <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pair_q   <= pair_d;
      stage_q  <= stage_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pair_d    = pair_q;
    stage_d   = stage_q;
    second_d  = second_q;
    tab_re    = 1'b0;
    samp_re   = 1'b0;
    samp_ra   = gperm;
    work_re   = 1'b0;
    work_ra_a = idx_q;
    work_ra_b = addr_b;
    work_we   = 1'b0;
    work_wa   = idx_q;
    work_wd   = {{(WorkW-SampleW){samp_rd[SampleW-1]}}, samp_rd};
    out_we    = 1'b0;
    out_wa    = sperm;
    out_wd    = sat ? {1'b1, res16} : {1'b0, shifted[SampleW-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d   = '0;
          state_d = ST_G_PERM;
        end
      end
      ST_G_PERM: begin
        tab_re  = 1'b1;
        state_d = ST_G_SAMP;
      end
      ST_G_SAMP: begin
        samp_re = 1'b1;
        state_d = ST_G_WR;
      end
      ST_G_WR: begin
        work_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_G_PERM;
        if (idx_q == msk) begin
          idx_d    = '0;
          pair_d   = '0;
          stage_d  = '0;
          second_d = 1'b0;
          state_d  = (lg == '0) ? ST_S_RD : ST_B_RD;
        end
      end
      ST_B_RD: begin
        work_re   = 1'b1;
        work_ra_a = addr_a;
        state_d   = ST_B_WA;
      end
      ST_B_WA: begin
        work_we = 1'b1;
        work_wa = addr_a;
        work_wd = work_rd_a + work_rd_b;
        state_d = ST_B_WB;
      end
      ST_B_WB: begin
        work_we = 1'b1;
        work_wa = addr_b;
        work_wd = work_rd_a - work_rd_b;
        pair_d  = pair_q + 1'b1;
        state_d = ST_B_RD;
        if (pair_q == msk[IdxW-1:1]) begin
          pair_d = '0;
          if (stage_q == lg - 4'd1) begin
            idx_d   = '0;
            state_d = second_q ? ST_F_RD : ST_S_RD;
          end else begin
            stage_d = stage_q + 4'd1;
          end
        end
      end
      ST_S_RD: begin
        work_re = 1'b1;
        tab_re  = 1'b1;
        state_d = ST_S_MUL;
      end
      ST_S_MUL: state_d = ST_S_WR;
      ST_S_WR: begin
        work_we = 1'b1;
        work_wd = neg_q ? -WorkW'(prod_q) : WorkW'(prod_q);
        idx_d   = idx_q + 1'b1;
        state_d = ST_S_RD;
        if (idx_q == msk) begin
          idx_d    = '0;
          pair_d   = '0;
          stage_d  = '0;
          second_d = 1'b1;
          state_d  = (lg == '0) ? ST_F_RD : ST_B_RD;
        end
      end
      ST_F_RD: begin
        work_re = 1'b1;
        tab_re  = 1'b1;
        state_d = ST_F_ADD;
      end
      ST_F_ADD: state_d = ST_F_WR;
      ST_F_WR: begin
        out_we  = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_F_RD;
        if (idx_q == msk) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_S_MUL) begin
      prod_q <= $signed(work_rd_a[26:0]) * $signed({1'b0, sing_rd});
      neg_q  <= sign_rd[0] ^ sign_rd[1];
    end
    if (state_q == ST_F_ADD) begin
      sum_q <= $signed(work_rd_a) + $signed(WorkW'(1) << (shamt - 5'd1));
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      rperm_mem[item_in_i.element_index] <= item_in_i.right_perm_entry;
      lperm_mem[item_in_i.element_index] <= item_in_i.left_perm_entry;
      sign_mem[item_in_i.element_index]  <= {item_in_i.left_sign_bit,
                                             item_in_i.right_sign_bit};
      sing_mem[item_in_i.element_index]  <= item_in_i.singular_entry;
    end
    if (tab_re) begin
      rperm_rd <= rperm_mem[idx_q];
      lperm_rd <= lperm_mem[idx_q];
      sign_rd  <= sign_mem[idx_q];
      sing_rd  <= sing_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_we) samp_mem[item_in_i.element_index] <= item_in_i.sample_value;
    if (samp_re) samp_rd <= samp_mem[samp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (work_re) begin
      work_rd_a <= work_mem[work_ra_a];
      work_rd_b <= work_mem[work_ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) out_mem[out_wa] <= out_wd;
    if (out_re) out_rd <= out_mem[item_in_i.element_index];
  end

  // result side
  assign move = rd_pend_q && (!ovalid_q || result_out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      if (move) ovalid_q <= 1'b1;
      else if (result_out_o.ready) ovalid_q <= 1'b0;
      if (out_re) rd_pend_q <= 1'b1;
      else if (move) rd_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_re) rd_idx_q <= item_in_i.element_index;
    if (move) begin
      result_out_o.result_value <= out_rd[SampleW-1:0];
      result_out_o.saturated    <= out_rd[SampleW];
      result_out_o.result_index <= rd_idx_q;
    end
  end

  assign result_out_o.valid = ovalid_q;

endmodule
